### rtl/core/tksi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_pkg
// Shared codes and types for the top-k sorted insertion core.
// ---------------------------------------------------------------------------
package tksi_pkg;

	localparam int FUNC_W      = 2;
	localparam int LIMIT_W     = 5;
	localparam int INDEX_W     = 4;
	localparam int COUNT_OUT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// per-cell control from the sequencing logic
	typedef struct packed {
		logic upd;      // admitted insert: cell loads or shifts
		logic held;     // cell lies within the held entries
		logic tail_sel; // cell is the last held entry
		logic rd_sel;   // cell is addressed by a read
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/tksi_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_cell
// One slot of the sorted list: holds a key and payload, flags whether the new
// key belongs at or before it, and takes its left neighbour's entry on a shift.
// ---------------------------------------------------------------------------
module tksi_cell #(
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire                          clk,
	input  wire tksi_pkg::cell_ctrl_t    ctrl,
	input  wire  [KEY_WIDTH-1:0]         new_key,
	input  wire  [PAYLOAD_WIDTH-1:0]     new_payload,
	input  wire                          prev_ins,
	input  wire  [KEY_WIDTH-1:0]         prev_key,
	input  wire  [PAYLOAD_WIDTH-1:0]     prev_payload,
	output logic                         ins,
	output logic [KEY_WIDTH-1:0]         key,
	output logic [PAYLOAD_WIDTH-1:0]     payload,
	output logic [KEY_WIDTH-1:0]         tail_key,
	output logic [KEY_WIDTH-1:0]         rd_key,
	output logic [PAYLOAD_WIDTH-1:0]     rd_payload
);

	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;

	// true from the insertion point onwards, since the held keys never increase
	assign ins = !(ctrl.held && (key_q >= new_key));

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			if (prev_ins) begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end else if (ins) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end
	end

	assign key        = key_q;
	assign payload    = payload_q;
	assign tail_key   = ctrl.tail_sel ? key_q : '0;
	assign rd_key     = ctrl.rd_sel ? key_q : '0;
	assign rd_payload = ctrl.rd_sel ? payload_q : '0;

endmodule
`default_nettype wire

### rtl/core/top_k_sorted_insert_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_sorted_insert_core
// Keeps the best entries by key in descending order in a row of cells; an
// insert places the new entry in the row, reads and clears are served too.
// ---------------------------------------------------------------------------
// the result strobe done follows an accepted start through pending_q and then done_q
// a new start is not accepted while busy; busy covers the cycle in which
// the cell row has been updated and the result is being registered
// the receiver cannot stall, so done always lasts exactly one cycle
// reset clears the entry count and sets depth_limit to 16; cells hold no reset
module top_k_sorted_insert_core #(
	parameter int MAX_ENTRIES   = 16,
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [tksi_pkg::FUNC_W-1:0]         func,
	input  wire  [KEY_WIDTH-1:0]                new_key,
	input  wire  [PAYLOAD_WIDTH-1:0]            new_payload,
	input  wire  [tksi_pkg::INDEX_W-1:0]        read_index,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [tksi_pkg::LIMIT_W-1:0]        cfg_data,
	output logic                                done,
	output logic                                admitted,
	output logic [tksi_pkg::COUNT_OUT_W-1:0]    entry_count,
	output logic [KEY_WIDTH-1:0]                tail_key,
	output logic [KEY_WIDTH-1:0]                entry_key,
	output logic [PAYLOAD_WIDTH-1:0]            entry_payload,
	output logic                                entry_valid
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [tksi_pkg::LIMIT_W-1:0]  depth_limit_q;
	logic [CW-1:0]                 count_q;
	logic                          pending_q;
	logic [tksi_pkg::FUNC_W-1:0]   func_q;
	logic [tksi_pkg::INDEX_W-1:0]  rd_idx_q;
	logic                          adm_q;

	logic                          done_q;
	logic                          admitted_q;
	logic [tksi_pkg::COUNT_OUT_W-1:0] entry_count_q;
	logic [KEY_WIDTH-1:0]          tail_key_q;
	logic [KEY_WIDTH-1:0]          entry_key_q;
	logic [PAYLOAD_WIDTH-1:0]      entry_payload_q;
	logic                          entry_valid_q;

	tksi_pkg::cell_ctrl_t          ctrl [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]        ins_v;
	logic [MAX_ENTRIES-1:0]        lim_mask;
	logic [KEY_WIDTH-1:0]          cell_key [MAX_ENTRIES];
	logic [PAYLOAD_WIDTH-1:0]      cell_payload [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0]          cell_tail [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0]          cell_rd_key [MAX_ENTRIES];
	logic [PAYLOAD_WIDTH-1:0]      cell_rd_pay [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]        rd_sel_v;

	logic                          accept;
	logic                          is_insert;
	logic [CW-1:0]                 lim;
	logic                          admit_c;
	logic                          upd;
	logic [CW:0]                   cnt_inc;
	logic [CW-1:0]                 count_nxt;
	logic [KEY_WIDTH-1:0]          tail_or;
	logic [KEY_WIDTH-1:0]          rd_key_or;
	logic [PAYLOAD_WIDTH-1:0]      rd_pay_or;

	assign accept    = start && !pending_q;
	assign busy      = pending_q;
	assign cfg_ready = 1'b1;
	assign is_insert = (func == tksi_pkg::FUNC_INSERT);

	// a limit above the cell count acts as the cell count
	assign lim = (32'(depth_limit_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(depth_limit_q);

	assign admit_c = (lim != '0) && ((ins_v & lim_mask) != '0);
	assign upd     = accept && is_insert && admit_c;
	assign cnt_inc = {1'b0, count_q} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		count_nxt = count_q;
		if (lim != '0) begin
			if (admit_c) begin
				count_nxt = (cnt_inc > {1'b0, lim}) ? lim : CW'(cnt_inc);
			end else begin
				count_nxt = (count_q > lim) ? lim : count_q;
			end
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign lim_mask[i]     = (32'(i) < 32'(lim));
		assign ctrl[i].upd      = upd;
		assign ctrl[i].held     = (32'(i) < 32'(count_q));
		assign ctrl[i].tail_sel = (32'(i) + 32'd1 == 32'(count_q));
		assign ctrl[i].rd_sel   = pending_q && (func_q == tksi_pkg::FUNC_READ)
			&& (32'(rd_idx_q) == 32'(i)) && (32'(i) < 32'(count_q));
		assign rd_sel_v[i]     = ctrl[i].rd_sel;

		if (i == 0) begin : g_head
			tksi_cell #(
				.KEY_WIDTH     (KEY_WIDTH),
				.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl[i]),
				.new_key      (new_key),
				.new_payload  (new_payload),
				.prev_ins     (1'b0),
				.prev_key     ('0),
				.prev_payload ('0),
				.ins          (ins_v[i]),
				.key          (cell_key[i]),
				.payload      (cell_payload[i]),
				.tail_key     (cell_tail[i]),
				.rd_key       (cell_rd_key[i]),
				.rd_payload   (cell_rd_pay[i])
			);
		end else begin : g_body
			tksi_cell #(
				.KEY_WIDTH     (KEY_WIDTH),
				.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl[i]),
				.new_key      (new_key),
				.new_payload  (new_payload),
				.prev_ins     (ins_v[i-1]),
				.prev_key     (cell_key[i-1]),
				.prev_payload (cell_payload[i-1]),
				.ins          (ins_v[i]),
				.key          (cell_key[i]),
				.payload      (cell_payload[i]),
				.tail_key     (cell_tail[i]),
				.rd_key       (cell_rd_key[i]),
				.rd_payload   (cell_rd_pay[i])
			);
		end
	end

	// at most one cell is selected for each of these
	always_comb begin
		tail_or   = '0;
		rd_key_or = '0;
		rd_pay_or = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			tail_or   = tail_or | cell_tail[i];
			rd_key_or = rd_key_or | cell_rd_key[i];
			rd_pay_or = rd_pay_or | cell_rd_pay[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= tksi_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			depth_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			pending_q <= accept;
			done_q    <= pending_q;
			if (accept) begin
				if (is_insert) begin
					count_q <= count_nxt;
				end else if (func == tksi_pkg::FUNC_CLEAR) begin
					count_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			rd_idx_q <= read_index;
			adm_q    <= is_insert && admit_c;
		end
	end

	// result transaction registered from the updated cell row
	always_ff @(posedge clk) begin
		if (pending_q) begin
			admitted_q      <= adm_q;
			entry_count_q   <= tksi_pkg::COUNT_OUT_W'(count_q);
			tail_key_q      <= tail_or;
			entry_key_q     <= rd_key_or;
			entry_payload_q <= rd_pay_or;
			entry_valid_q   <= (rd_sel_v != '0);
		end
	end

	assign done          = done_q;
	assign admitted      = admitted_q;
	assign entry_count   = entry_count_q;
	assign tail_key      = tail_key_q;
	assign entry_key     = entry_key_q;
	assign entry_payload = entry_payload_q;
	assign entry_valid   = entry_valid_q;

endmodule
`default_nettype wire

### rtl/core/tksi_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_checker
// Port-level checks on the sorted insertion core, bound to the top level.
// ---------------------------------------------------------------------------
module tksi_checker #(
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire                          done,
	input  wire                          admitted,
	input  wire  [KEY_WIDTH-1:0]         entry_key,
	input  wire  [PAYLOAD_WIDTH-1:0]     entry_payload,
	input  wire                          entry_valid
);

	// an accepted transaction raises busy in the cycle after, blocking the next start
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// a read never admits and an insert never returns an entry
	a_read_not_admit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(entry_valid && admitted))
		else $error("read and admit reported together");

	a_empty_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !entry_valid |-> (entry_key == '0) && (entry_payload == '0))
		else $error("entry fields not zero without a valid read");

endmodule

bind top_k_sorted_insert_core tksi_checker #(
	.KEY_WIDTH     (KEY_WIDTH),
	.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_tksi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.admitted      (admitted),
	.entry_key     (entry_key),
	.entry_payload (entry_payload),
	.entry_valid   (entry_valid)
);
`default_nettype wire

### tb/tb_top_k_sorted_insert_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top_k_sorted_insert_core
// Self-checking bench for the top-k sorted insertion core. A directed run
// covers ties, extremes, lowered and zero limits and reads past the end,
// then randomised phases at several depth limits exercise fill, overflow and
// clear. Every result is compared with a behavioural copy of the list.
// ---------------------------------------------------------------------------
module tb_top_k_sorted_insert_core;

	localparam int LIST_CAP = 16;
	localparam int TAIL_ITEMS = 120;
	localparam logic [tksi_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

	typedef struct packed {
		logic                          is_limit;
		logic [tksi_pkg::LIMIT_W-1:0]  limit;
		logic [tksi_pkg::FUNC_W-1:0]   op;
		logic [31:0]                   key;
		logic [31:0]                   payload;
		logic [tksi_pkg::INDEX_W-1:0]  index;
	} list_op_t;

	typedef struct packed {
		logic                              admitted;
		logic [tksi_pkg::COUNT_OUT_W-1:0]  entry_count;
		logic [31:0]                       tail_key;
		logic [31:0]                       entry_key;
		logic [31:0]                       entry_payload;
		logic                              entry_valid;
	} list_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [tksi_pkg::FUNC_W-1:0] func = '0;
	logic [31:0] new_key = '0;
	logic [31:0] new_payload = '0;
	logic [tksi_pkg::INDEX_W-1:0] read_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tksi_pkg::LIMIT_W-1:0] cfg_data = '0;
	logic done;
	logic admitted;
	logic [tksi_pkg::COUNT_OUT_W-1:0] entry_count;
	logic [31:0] tail_key;
	logic [31:0] entry_key;
	logic [31:0] entry_payload;
	logic entry_valid;

	top_k_sorted_insert_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.new_key      (new_key),
		.new_payload  (new_payload),
		.read_index   (read_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.admitted     (admitted),
		.entry_count  (entry_count),
		.tail_key     (tail_key),
		.entry_key    (entry_key),
		.entry_payload(entry_payload),
		.entry_valid  (entry_valid)
	);

	// behavioural copy of the list
	logic [31:0] ranked_keys [LIST_CAP];
	logic [31:0] ranked_pay [LIST_CAP];
	int unsigned ranked_count = 0;
	logic [tksi_pkg::LIMIT_W-1:0] keep_limit = tksi_pkg::LIMIT_RESET;

	list_op_t stim_q[$];
	list_result_t want_q[$];
	list_op_t cur_op;
	int n_issued = 0;
	int n_done = 0;
	int errors = 0;
	int gap_left = 0;
	bit gappy = 1'b1;

	function automatic list_result_t rank_op(input list_op_t o);
		list_result_t r;
		int unsigned lim;
		int unsigned pos;
		int unsigned grown;
		int k;
		r = '0;
		case (o.op)
			tksi_pkg::FUNC_INSERT: begin
				lim = (keep_limit > LIST_CAP) ? LIST_CAP : keep_limit;
				if (lim != 0) begin
					pos = 0;
					while (pos < ranked_count && ranked_keys[pos] >= o.key)
						pos++;
					if (pos < lim) begin
						grown = (ranked_count + 1 > lim) ? lim : ranked_count + 1;
						for (k = grown - 1; k > int'(pos); k--) begin
							ranked_keys[k] = ranked_keys[k-1];
							ranked_pay[k] = ranked_pay[k-1];
						end
						ranked_keys[pos] = o.key;
						ranked_pay[pos] = o.payload;
						ranked_count = grown;
						r.admitted = 1'b1;
					end else if (ranked_count > lim) begin
						ranked_count = lim;
					end
				end
			end
			tksi_pkg::FUNC_READ: begin
				if (o.index < ranked_count) begin
					r.entry_key = ranked_keys[o.index];
					r.entry_payload = ranked_pay[o.index];
					r.entry_valid = 1'b1;
				end
			end
			tksi_pkg::FUNC_CLEAR: ranked_count = 0;
			default: ;
		endcase
		r.entry_count = tksi_pkg::COUNT_OUT_W'(ranked_count);
		if (ranked_count > 0)
			r.tail_key = ranked_keys[ranked_count-1];
		return r;
	endfunction

	task automatic add_op(input logic [tksi_pkg::FUNC_W-1:0] op, input logic [31:0] key,
			input logic [31:0] payload, input logic [tksi_pkg::INDEX_W-1:0] index);
		list_op_t o;
		o = '0;
		o.op = op;
		o.key = key;
		o.payload = payload;
		o.index = index;
		stim_q.push_back(o);
	endtask

	task automatic add_limit(input logic [tksi_pkg::LIMIT_W-1:0] limit);
		list_op_t o;
		o = '0;
		o.is_limit = 1'b1;
		o.limit = limit;
		stim_q.push_back(o);
	endtask

	// mix of ties, extremes and full-range keys
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2, 3, 4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (start && !busy) begin
				want_q.push_back(rank_op(cur_op));
				n_issued++;
				if ($urandom_range(0, 29) == 0)
					gappy = !gappy;
				if (gappy && stim_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 17);
			end
			if (cfg_valid && cfg_ready)
				keep_limit = cfg_data;

			if ((start && busy) || (cfg_valid && !cfg_ready)) begin
				// transaction still on offer
			end else if (gap_left > 0 || stim_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (stim_q[0].is_limit) begin
				// limit changes only once every result is back
				start <= 1'b0;
				cfg_valid <= (n_issued == n_done);
				if (n_issued == n_done) begin
					cfg_data <= stim_q[0].limit;
					void'(stim_q.pop_front());
				end
			end else begin
				cur_op = stim_q.pop_front();
				start <= 1'b1;
				cfg_valid <= 1'b0;
				func <= cur_op.op;
				new_key <= cur_op.key;
				new_payload <= cur_op.payload;
				read_index <= cur_op.index;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		list_result_t w;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual count %0d",
					$time, entry_count);
				errors++;
			end else begin
				w = want_q.pop_front();
				check_field("admitted", 32'(w.admitted), 32'(admitted));
				check_field("entry_count", 32'(w.entry_count), 32'(entry_count));
				check_field("tail_key", w.tail_key, tail_key);
				check_field("entry_key", w.entry_key, entry_key);
				check_field("entry_payload", w.entry_payload, entry_payload);
				check_field("entry_valid", 32'(w.entry_valid), 32'(entry_valid));
				n_done <= n_done + 1;
			end
		end
	end

	initial begin
		logic [tksi_pkg::LIMIT_W-1:0] phase_limits [12];
		int p;
		int i;
		int r;
		phase_limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17,
			5'd2, 5'd16, 5'd5, 5'd20, 5'd12, 5'd16};
		phase_limits[11] = tksi_pkg::LIMIT_W'($urandom_range(0, 31));

		// directed: ties, extremes, overflow, read past the end, unused code
		add_limit(5'd4);
		add_op(tksi_pkg::FUNC_INSERT, 32'd100, 32'd1, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'd100, 32'd2, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'd0, 32'd0, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'd50, 32'd3, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'd0, 32'd4, 4'd0);
		for (i = 0; i < 5; i++)
			add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, tksi_pkg::INDEX_W'(i));
		add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, 4'd15);
		add_op(FUNC_NOP, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
		// lowered limit cuts the list even when nothing is admitted
		add_limit(5'd2);
		add_op(tksi_pkg::FUNC_INSERT, 32'd0, 32'd5, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'hffff_ffff, 32'd7, 4'd0);
		add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, 4'd1);
		add_limit(5'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'hffff_ffff, 32'd9, 4'd0);
		add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, 4'd0);
		// limit above the list size acts as the full size
		add_limit(5'd31);
		add_op(tksi_pkg::FUNC_CLEAR, 32'd0, 32'd0, 4'd0);
		add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'haaaa_aaaa, 32'h5555_5555, 4'd0);
		add_op(tksi_pkg::FUNC_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 4'd0);
		add_op(tksi_pkg::FUNC_READ, 32'd0, 32'd0, 4'd1);
		add_op(tksi_pkg::FUNC_CLEAR, 32'd0, 32'd0, 4'd0);

		for (p = 0; p < 12; p++) begin
			add_limit(phase_limits[p]);
			for (i = 0; i < 105; i++) begin
				r = $urandom_range(0, 99);
				if (r < 58)
					add_op(tksi_pkg::FUNC_INSERT, pick_key(), $urandom,
						tksi_pkg::INDEX_W'($urandom));
				else if (r < 91)
					add_op(tksi_pkg::FUNC_READ, $urandom, $urandom,
						tksi_pkg::INDEX_W'($urandom));
				else if (r < 94)
					add_op(tksi_pkg::FUNC_CLEAR, $urandom, $urandom,
						tksi_pkg::INDEX_W'($urandom));
				else
					add_op(FUNC_NOP, $urandom, $urandom, tksi_pkg::INDEX_W'($urandom));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || start || cfg_valid || n_issued != n_done)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && want_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
